>>> sv/wep_pkg.sv
// ----------------------------------------------------------------------------
// wep_pkg: shared types and constants for the frame cipher
// Sizes, register indexes, status codes and the CRC byte step.
// ----------------------------------------------------------------------------
package wep_pkg;

  localparam int KEY_BYTES  = 13;
  localparam int IV_BYTES   = 3;
  localparam int SEED_BYTES = KEY_BYTES + IV_BYTES;
  localparam int SEED_W     = $clog2(SEED_BYTES);

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_IV       = 2'd2;
  localparam logic [1:0] REG_DIR      = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_SHORT    = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL,
    S_KS_RD_I,
    S_KS_RD_J,
    S_KS_WR_I,
    S_KS_WR_J,
    S_RD_I,
    S_RD_J,
    S_WR_I,
    S_WR_J,
    S_RD_K,
    S_EMIT
  } wep_state_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int n = 0; n < 8; n++) begin
      r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
    end
    return r;
  endfunction

endpackage

>>> sv/wep_ram.sv
// ----------------------------------------------------------------------------
// wep_ram: generic single port ram
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module wep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> sv/wep_frame_encrypt_decrypt.sv
// ----------------------------------------------------------------------------
// wep_frame_encrypt_decrypt: rc4 cipher with crc-32 icv, one byte per beat
// Top level: sequencer around a single port s-box ram.
// ----------------------------------------------------------------------------
// Usage: write key_low (0), key_high (1), init_vector (2) and direction (3)
// on the cfg channel while no frame byte is in work. Frame bytes enter on the
// in_ channel, in_last on the final one; results leave on the out_ channel.
// The first byte of a frame triggers the key schedule on the s-box ram: all
// 256 entries are filled, then 256 swap steps follow (s[i] read, s[j] read,
// two swap writes). Each byte then runs through s[i] read, s[j] read, two
// swap writes, keystream read and the result state, all through the one
// ram port; the sequencer then goes back to idle, the only state in which a
// new byte is taken. Encrypt gives one beat per byte and four icv beats
// after the last byte, each another keystream step. Decrypt holds four
// bytes, then gives one beat per byte; a frame of four bytes or fewer gives
// a single status beat. in_stall is low only in the idle state; the result
// register parts the two sides, so a new byte is taken while a beat still
// waits. While out_stall is high the result beat holds and the next result
// waits in its last cycle. Reset clears the config registers, indices and
// counters, sets the crc to all ones; the s-box is rebuilt at frame start.
// ----------------------------------------------------------------------------
module wep_frame_encrypt_decrypt
  import wep_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_out_byte,
  output logic        out_carries_byte,
  output logic        out_frame_end,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] key_low_r;
  logic [39:0] key_high_r;
  logic [23:0] iv_r;
  logic        dir_r;

  wep_state_t state_r, state_nxt;
  logic [7:0]  cnt_r, cnt_nxt;       // fill / schedule index
  logic [SEED_W-1:0] seed_r, seed_nxt;
  logic [7:0]  i_r, i_nxt, j_r, j_nxt;
  logic [7:0]  si_r, si_nxt, sj_r, sj_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [7:0]  hold_r [4];
  logic [7:0]  hold_nxt [4];
  logic [2:0]  held_r, held_nxt;
  logic        mid_r, mid_nxt, fdir_r, fdir_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        last_r, last_nxt;
  logic [1:0]  icv_r, icv_nxt;       // icv bytes left after current one
  logic        icv_mode_r, icv_mode_nxt;
  logic        ov_r, ov_nxt;
  logic [7:0]  ob_r, ob_nxt;
  logic        oc_r, oc_nxt, oe_r, oe_nxt;
  logic [1:0]  os_r, os_nxt;

  logic       we;
  logic [7:0] addr, wdata, rdata;
  logic [7:0] sb;
  logic       in_take, out_free, icv_more;

  wep_ram #(.WIDTH(8), .DEPTH(256)) u_sbox (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !ov_r || !out_stall;
  // another keystream step follows for an icv byte
  assign icv_more  = !fdir_r && (icv_mode_r ? (icv_r != 2'd0) : last_r);
  assign out_valid        = ov_r;
  assign out_out_byte     = ob_r;
  assign out_carries_byte = oc_r;
  assign out_frame_end    = oe_r;
  assign out_status       = os_r;

  always_comb begin
    logic [127:0] seed_all;
    seed_all = {key_high_r, key_low_r, iv_r};
    sb = seed_all[{seed_r, 3'd0} +: 8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r <= '0; key_high_r <= '0; iv_r <= '0; dir_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KEY_LOW:  key_low_r  <= cfg_data;
        REG_KEY_HIGH: key_high_r <= cfg_data[39:0];
        REG_IV:       iv_r       <= cfg_data[23:0];
        REG_DIR:      dir_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_take) state_nxt = mid_r ? S_RD_I : S_FILL;
      S_FILL:    if (cnt_r == 8'hFF) state_nxt = S_KS_RD_I;
      S_KS_RD_I: state_nxt = S_KS_RD_J;
      S_KS_RD_J: state_nxt = S_KS_WR_I;
      S_KS_WR_I: state_nxt = S_KS_WR_J;
      S_KS_WR_J: state_nxt = (cnt_r == 8'hFF) ? S_RD_I : S_KS_RD_I;
      S_RD_I:    state_nxt = S_RD_J;
      S_RD_J:    state_nxt = S_WR_I;
      S_WR_I:    state_nxt = S_WR_J;
      S_WR_J:    state_nxt = S_RD_K;
      S_RD_K:    state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free) state_nxt = icv_more ? S_RD_I : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    logic [7:0] d, p;
    logic [31:0] c1;
    cnt_nxt = cnt_r; seed_nxt = seed_r; i_nxt = i_r; j_nxt = j_r;
    si_nxt = si_r; sj_nxt = sj_r; crc_nxt = crc_r; held_nxt = held_r;
    for (int n = 0; n < 4; n++) hold_nxt[n] = hold_r[n];
    mid_nxt = mid_r; fdir_nxt = fdir_r; byte_nxt = byte_r; last_nxt = last_r;
    icv_nxt = icv_r; icv_mode_nxt = icv_mode_r;
    ov_nxt = ov_r && out_stall; ob_nxt = ob_r; oc_nxt = oc_r; oe_nxt = oe_r;
    os_nxt = os_r;
    we = 1'b0; addr = 8'd0; wdata = 8'd0;
    d = 8'd0; p = 8'd0; c1 = 32'd0;
    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          byte_nxt = in_data_byte; last_nxt = in_last;
          icv_mode_nxt = 1'b0;
          if (!mid_r) begin
            cnt_nxt = 8'd0; seed_nxt = '0; j_nxt = 8'd0; i_nxt = 8'd0;
            crc_nxt = CRC_ONES; held_nxt = 3'd0; fdir_nxt = dir_r;
          end
          mid_nxt = !in_last;
        end
      end
      S_FILL: begin
        we = 1'b1; addr = cnt_r; wdata = cnt_r;
        cnt_nxt = cnt_r + 8'd1;
      end
      S_KS_RD_I: begin
        addr = cnt_r;
      end
      S_KS_RD_J: begin
        // rdata is s[cnt]
        si_nxt = rdata;
        j_nxt = j_r + rdata + sb;
        addr = j_r + rdata + sb;
      end
      S_KS_WR_I: begin
        we = 1'b1; addr = cnt_r; wdata = rdata;
      end
      S_KS_WR_J: begin
        we = 1'b1; addr = j_r; wdata = si_r;
        cnt_nxt = cnt_r + 8'd1;
        seed_nxt = (seed_r == SEED_W'(SEED_BYTES - 1)) ? '0 : seed_r + 1'b1;
        if (cnt_r == 8'hFF) begin
          i_nxt = 8'd0; j_nxt = 8'd0;
        end
      end
      S_RD_I: begin
        addr = i_r + 8'd1;
        i_nxt = i_r + 8'd1;
      end
      S_RD_J: begin
        si_nxt = rdata;
        j_nxt = j_r + rdata;
        addr = j_r + rdata;
      end
      S_WR_I: begin
        sj_nxt = rdata;
        we = 1'b1; addr = i_r; wdata = rdata;
      end
      S_WR_J: begin
        we = 1'b1; addr = j_r; wdata = si_r;
      end
      S_RD_K: begin
        addr = si_r + sj_r;
      end
      S_EMIT: begin
        // address held so the keystream byte stays on rdata while stalled
        addr = si_r + sj_r;
        if (out_free) begin
          d = byte_r ^ rdata;
          if (icv_mode_r) begin
            ov_nxt = 1'b1; ob_nxt = d; oc_nxt = 1'b1; oe_nxt = (icv_r == 2'd0);
            os_nxt = ST_OK;
            if (icv_r != 2'd0) begin
              icv_nxt = icv_r - 2'd1;
              byte_nxt = crc_r[15:8];
              crc_nxt = {8'd0, crc_r[31:8]};
            end else begin
              icv_mode_nxt = 1'b0;
            end
          end else if (!fdir_r) begin
            c1 = crc_byte(crc_r, byte_r);
            crc_nxt = c1;
            ov_nxt = 1'b1; ob_nxt = d; oc_nxt = 1'b1; oe_nxt = 1'b0; os_nxt = ST_OK;
            if (last_r) begin
              icv_mode_nxt = 1'b1; icv_nxt = 2'd3;
              byte_nxt = ~c1[7:0];
              crc_nxt = ~c1;
            end
          end else if (held_r < 3'd4) begin
            hold_nxt[held_r[1:0]] = d;
            held_nxt = held_r + 3'd1;
            if (last_r) begin
              ov_nxt = 1'b1; ob_nxt = 8'd0; oc_nxt = 1'b0; oe_nxt = 1'b1;
              os_nxt = ST_SHORT;
            end
          end else begin
            p = hold_r[0];
            hold_nxt[0] = hold_r[1]; hold_nxt[1] = hold_r[2];
            hold_nxt[2] = hold_r[3]; hold_nxt[3] = d;
            c1 = crc_byte(crc_r, p);
            crc_nxt = c1;
            ov_nxt = 1'b1; ob_nxt = p; oc_nxt = 1'b1; oe_nxt = last_r; os_nxt = ST_OK;
            if (last_r && ({d, hold_r[3], hold_r[2], hold_r[1]} != ~c1)) begin
              os_nxt = ST_MISMATCH;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mid_r <= 1'b0; fdir_r <= 1'b0; held_r <= 3'd0; crc_r <= CRC_ONES;
      i_r <= 8'd0; j_r <= 8'd0; ov_r <= 1'b0; icv_mode_r <= 1'b0;
      cnt_r <= 8'd0; seed_r <= '0; icv_r <= 2'd0;
    end else begin
      state_r <= state_nxt;
      mid_r <= mid_nxt; fdir_r <= fdir_nxt; held_r <= held_nxt; crc_r <= crc_nxt;
      i_r <= i_nxt; j_r <= j_nxt; ov_r <= ov_nxt; icv_mode_r <= icv_mode_nxt;
      cnt_r <= cnt_nxt; seed_r <= seed_nxt; icv_r <= icv_nxt;
    end
    si_r <= si_nxt; sj_r <= sj_nxt;
    byte_r <= byte_nxt; last_r <= last_nxt;
    ob_r <= ob_nxt; oc_r <= oc_nxt; oe_r <= oe_nxt; os_r <= os_nxt;
    for (int n = 0; n < 4; n++) hold_r[n] <= hold_nxt[n];
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid &&
      $stable({out_out_byte, out_carries_byte, out_frame_end, out_status}));

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_carries_byte |-> out_out_byte == 8'd0);

  a_status_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_end |-> out_status == ST_OK);

  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> in_stall);

endmodule
